>>> hdl/rpss_pkg.sv
// ============================================================================
// rpss_pkg
// Shared types and constants for the regex pattern safety screen.
// ============================================================================
`default_nettype none

package rpss_pkg;

    localparam int BYTE_W     = 8;
    localparam int LIMIT_W    = 20;
    localparam int BOUND_W    = 24;
    localparam int APB_DATA_W = 32;
    localparam int APB_ADDR_W = 3;

    // Register word index, taken from paddr[2]
    localparam logic REG_MAX_REPEAT = 1'b0;

    localparam logic [LIMIT_W-1:0] LIMIT_RESET = 20'd100000;

    localparam logic [BYTE_W-1:0] CH_NUL       = 8'h00;
    localparam logic [BYTE_W-1:0] CH_LBRACE    = 8'h7B;
    localparam logic [BYTE_W-1:0] CH_COMMA     = 8'h2C;
    localparam logic [BYTE_W-1:0] CH_LBRACKET  = 8'h5B;
    localparam logic [BYTE_W-1:0] CH_RBRACKET  = 8'h5D;
    localparam logic [BYTE_W-1:0] CH_CARET     = 8'h5E;
    localparam logic [BYTE_W-1:0] CH_BACKSLASH = 8'h5C;
    localparam logic [BYTE_W-1:0] CH_COLON     = 8'h3A;
    localparam logic [BYTE_W-1:0] CH_DOT       = 8'h2E;
    localparam logic [BYTE_W-1:0] CH_EQUAL     = 8'h3D;
    localparam logic [BYTE_W-1:0] CH_ZERO      = 8'h30;
    localparam logic [BYTE_W-1:0] CH_ONE       = 8'h31;
    localparam logic [BYTE_W-1:0] CH_NINE      = 8'h39;

    typedef enum logic [2:0] {
        VERDICT_ACCEPT    = 3'd0,
        VERDICT_NUL       = 3'd1,
        VERDICT_TOO_LARGE = 3'd2,
        VERDICT_UNBOUNDED = 3'd3,
        VERDICT_BACKREF   = 3'd4
    } verdict_t;

    typedef enum logic [1:0] {
        RP_NORMAL = 2'd0,
        RP_LOWER  = 2'd1,
        RP_UPPER  = 2'd2
    } repeat_phase_t;

    typedef enum logic [1:0] {
        RF_NONE      = 2'd0,
        RF_BIG       = 2'd1,
        RF_UNBOUNDED = 2'd2
    } repeat_fault_t;

    typedef enum logic [2:0] {
        BP_OUTSIDE = 3'd0,
        BP_OPEN    = 3'd1,
        BP_CARET   = 3'd2,
        BP_BODY    = 3'd3,
        BP_LBRACK  = 3'd4,
        BP_CLASS   = 3'd5,
        BP_CLASS_K = 3'd6
    } bracket_phase_t;

    // One pattern byte handed from the input register to the scanner
    typedef struct packed {
        logic              step;
        logic              last;
        logic [BYTE_W-1:0] pattern_byte;
    } scan_in_t;

endpackage

`default_nettype wire

>>> hdl/rpss_byte_if.sv
// ============================================================================
// rpss_byte_if
// Valid/ready channel carrying one pattern byte and its end marker.
// ============================================================================
`default_nettype none

interface rpss_byte_if;
    import rpss_pkg::*;

    logic              valid;
    logic              ready;
    logic [BYTE_W-1:0] pattern_byte;
    logic              last;

    modport source (output valid, output pattern_byte, output last, input ready);
    modport sink   (input valid, input pattern_byte, input last, output ready);
endinterface

`default_nettype wire

>>> hdl/rpss_verdict_if.sv
// ============================================================================
// rpss_verdict_if
// Valid/ready channel carrying one screening verdict.
// ============================================================================
`default_nettype none

interface rpss_verdict_if;
    import rpss_pkg::*;

    logic     valid;
    logic     ready;
    verdict_t verdict;

    modport source (output valid, output verdict, input ready);
    modport sink   (input valid, input verdict, output ready);
endinterface

`default_nettype wire

>>> hdl/rpss_scan.sv
// ============================================================================
// rpss_scan
// Repeat-count and bracket/backreference scanners, one byte per step.
// ============================================================================
`default_nettype none

module rpss_scan (
    input  wire logic                             clk,
    input  wire logic                             rst_n,
    input  wire rpss_pkg::scan_in_t               scan_in,
    input  wire logic [rpss_pkg::LIMIT_W-1:0]     max_repeat_product,
    output rpss_pkg::verdict_t                    verdict
);
    import rpss_pkg::*;

    repeat_phase_t        rp_reg, rp_next;
    logic                 resc_reg, resc_next;
    logic                 seen_reg, seen_next;
    logic [BOUND_W-1:0]   bound_reg, bound_next;
    logic [LIMIT_W-1:0]   prod_reg, prod_next;
    repeat_fault_t        fault_reg, fault_next;
    bracket_phase_t       bp_reg, bp_next;
    logic [BYTE_W-1:0]    delim_reg, delim_next;
    logic                 besc_reg, besc_next;
    logic                 nul_reg, nul_next;
    logic                 bref_reg, bref_next;

    logic [BYTE_W-1:0]    b;
    logic                 is_digit;
    logic [3:0]           digit;
    logic [BOUND_W-1:0]   bound_step;
    logic                 close_now;
    logic                 close_end;
    logic                 rescan;
    logic [LIMIT_W-1:0]   factor_raw;
    logic [LIMIT_W-1:0]   factor;
    logic [2*LIMIT_W-1:0] close_product;
    repeat_phase_t        rp_byte;
    logic                 seen_byte;
    logic [BOUND_W-1:0]   bound_byte;
    repeat_fault_t        fault_byte;
    repeat_fault_t        fault_end;
    logic                 outside_path;

    function automatic bracket_phase_t body_step(input logic [BYTE_W-1:0] c);
        bracket_phase_t p;
        if (c == CH_RBRACKET)
            p = BP_OUTSIDE;
        else if (c == CH_LBRACKET)
            p = BP_LBRACK;
        else
            p = BP_BODY;
        return p;
    endfunction

    assign b          = scan_in.pattern_byte;
    assign is_digit   = (b >= CH_ZERO) && (b <= CH_NINE);
    assign digit      = 4'(b - CH_ZERO);
    assign bound_step = BOUND_W'({bound_reg, 3'b000}) + BOUND_W'({bound_reg, 1'b0})
                        + BOUND_W'(digit);

    // Repeat scanner: byte pass, then end-of-pattern closing
    always_comb
    begin
        rp_byte    = rp_reg;
        resc_next  = resc_reg;
        seen_byte  = seen_reg;
        bound_byte = bound_reg;
        fault_byte = fault_reg;
        close_now  = 1'b0;
        rescan     = 1'b0;
        if (fault_reg == RF_NONE)
        begin
            if (resc_reg)
            begin
                resc_next = 1'b0;
            end
            else
            begin
                rescan = 1'b1;
                if (rp_reg == RP_LOWER || rp_reg == RP_UPPER)
                begin
                    rescan = 1'b0;
                    if (is_digit)
                    begin
                        bound_byte = bound_step;
                        seen_byte  = 1'b1;
                        if (bound_step > BOUND_W'(max_repeat_product))
                            fault_byte = RF_BIG;
                    end
                    else if (rp_reg == RP_LOWER && b == CH_COMMA)
                    begin
                        rp_byte    = RP_UPPER;
                        bound_byte = '0;
                        seen_byte  = 1'b0;
                    end
                    else if (seen_reg)
                    begin
                        close_now = 1'b1;
                        rp_byte   = RP_NORMAL;
                    end
                    else if (rp_reg == RP_UPPER)
                    begin
                        fault_byte = RF_UNBOUNDED;
                    end
                    else
                    begin
                        // literal brace: scan this byte again as normal text
                        rp_byte = RP_NORMAL;
                        rescan  = 1'b1;
                    end
                end
                if (rescan)
                begin
                    if (b == CH_BACKSLASH)
                    begin
                        resc_next = 1'b1;
                    end
                    else if (b == CH_LBRACE)
                    begin
                        rp_byte    = RP_LOWER;
                        bound_byte = '0;
                        seen_byte  = 1'b0;
                    end
                end
            end
        end

        close_end = 1'b0;
        fault_end = fault_byte;
        if (scan_in.last && fault_byte == RF_NONE)
        begin
            if (rp_byte == RP_LOWER && seen_byte)
                close_end = 1'b1;
            else if (rp_byte == RP_UPPER)
            begin
                if (seen_byte)
                    close_end = 1'b1;
                else
                    fault_end = RF_UNBOUNDED;
            end
        end
    end

    // A closing bound never exceeds the limit, so 20 bits of it suffice
    assign factor_raw    = close_now ? bound_reg[LIMIT_W-1:0] : bound_byte[LIMIT_W-1:0];
    assign factor        = (factor_raw == '0) ? LIMIT_W'(1) : factor_raw;
    assign close_product = {{LIMIT_W{1'b0}}, prod_reg} * {{LIMIT_W{1'b0}}, factor};

    always_comb
    begin
        rp_next    = rp_byte;
        seen_next  = seen_byte;
        bound_next = bound_byte;
        prod_next  = prod_reg;
        fault_next = fault_end;
        if (close_now || close_end)
        begin
            prod_next = close_product[LIMIT_W-1:0];
            if (close_product > (2*LIMIT_W)'(max_repeat_product))
                fault_next = RF_BIG;
        end
    end

    // Bracket and backreference scanner
    always_comb
    begin
        bp_next      = bp_reg;
        delim_next   = delim_reg;
        besc_next    = besc_reg;
        bref_next    = bref_reg;
        outside_path = 1'b0;
        case (bp_reg)
            BP_OPEN:
            begin
                if (b == CH_CARET)
                    bp_next = BP_CARET;
                else if (b == CH_RBRACKET)
                    bp_next = BP_BODY;
                else
                    bp_next = body_step(b);
            end
            BP_CARET:
            begin
                if (b == CH_RBRACKET)
                    bp_next = BP_BODY;
                else
                    bp_next = body_step(b);
            end
            BP_BODY:
            begin
                bp_next = body_step(b);
            end
            BP_LBRACK:
            begin
                if (b == CH_COLON || b == CH_DOT || b == CH_EQUAL)
                begin
                    delim_next = b;
                    bp_next    = BP_CLASS;
                end
                else
                begin
                    bp_next = body_step(b);
                end
            end
            BP_CLASS:
            begin
                if (b == delim_reg)
                    bp_next = BP_CLASS_K;
            end
            BP_CLASS_K:
            begin
                if (b == CH_RBRACKET)
                    bp_next = BP_BODY;
                else if (b != delim_reg)
                    bp_next = BP_CLASS;
            end
            default:
            begin
                outside_path = 1'b1;
            end
        endcase
        if (outside_path)
        begin
            bp_next = BP_OUTSIDE;
            if (besc_reg)
            begin
                besc_next = 1'b0;
                if (b >= CH_ONE && b <= CH_NINE)
                    bref_next = 1'b1;
            end
            else if (b == CH_LBRACKET)
                bp_next = BP_OPEN;
            else if (b == CH_BACKSLASH)
                besc_next = 1'b1;
        end
    end

    assign nul_next = nul_reg || (b == CH_NUL);

    always_comb
    begin
        if (nul_next)
            verdict = VERDICT_NUL;
        else if (fault_next == RF_BIG)
            verdict = VERDICT_TOO_LARGE;
        else if (fault_next == RF_UNBOUNDED)
            verdict = VERDICT_UNBOUNDED;
        else if (bref_next)
            verdict = VERDICT_BACKREF;
        else
            verdict = VERDICT_ACCEPT;
    end

    // Advance on every step; return to the clean state after the last byte
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rp_reg    <= RP_NORMAL;
            resc_reg  <= 1'b0;
            seen_reg  <= 1'b0;
            bound_reg <= '0;
            prod_reg  <= LIMIT_W'(1);
            fault_reg <= RF_NONE;
            bp_reg    <= BP_OUTSIDE;
            delim_reg <= '0;
            besc_reg  <= 1'b0;
            nul_reg   <= 1'b0;
            bref_reg  <= 1'b0;
        end
        else if (scan_in.step)
        begin
            if (scan_in.last)
            begin
                rp_reg    <= RP_NORMAL;
                resc_reg  <= 1'b0;
                seen_reg  <= 1'b0;
                bound_reg <= '0;
                prod_reg  <= LIMIT_W'(1);
                fault_reg <= RF_NONE;
                bp_reg    <= BP_OUTSIDE;
                delim_reg <= '0;
                besc_reg  <= 1'b0;
                nul_reg   <= 1'b0;
                bref_reg  <= 1'b0;
            end
            else
            begin
                rp_reg    <= rp_next;
                resc_reg  <= resc_next;
                seen_reg  <= seen_next;
                bound_reg <= bound_next;
                prod_reg  <= prod_next;
                fault_reg <= fault_next;
                bp_reg    <= bp_next;
                delim_reg <= delim_next;
                besc_reg  <= besc_next;
                nul_reg   <= nul_next;
                bref_reg  <= bref_next;
            end
        end
    end

endmodule

`default_nettype wire

>>> hdl/regex_pattern_safety_screen.sv
// ============================================================================
// regex_pattern_safety_screen
// Byte-serial screen for extended regular expression patterns.
// ============================================================================
// Feed the pattern one byte per item on pattern_ch, with last set on the final
// byte; one verdict item comes out on verdict_ch for each pattern. The block
// takes one byte every clock cycle: each accepted byte lands in an input
// register, from which a single pass of scanner logic (one 20x20 multiply
// for closing a repeat count) updates the scan state. The verdict is loaded
// into an output register as the last byte leaves the input register and is
// held there until taken; the input stalls only when a last byte is waiting
// while the previous verdict still sits unclaimed. After the last byte
// all scan state returns to its reset value, so patterns may follow back to
// back. max_repeat_product sits at APB address 0 (20 bits, reset 100000) and
// must only be written while no pattern is in flight.
// ============================================================================
`default_nettype none

module regex_pattern_safety_screen (
    input  wire logic                              clk,
    input  wire logic                              rst_n,
    rpss_byte_if.sink                              pattern_ch,
    rpss_verdict_if.source                         verdict_ch,
    input  wire logic                              psel,
    input  wire logic                              penable,
    input  wire logic                              pwrite,
    input  wire logic [rpss_pkg::APB_ADDR_W-1:0]   paddr,
    input  wire logic [rpss_pkg::APB_DATA_W-1:0]   pwdata,
    output logic      [rpss_pkg::APB_DATA_W-1:0]   prdata,
    output logic                                   pready
);
    import rpss_pkg::*;

    // limit register
    logic [LIMIT_W-1:0] limit_reg;
    logic               cfg_write;
    logic               cfg_hit;

    // input register
    logic               in_valid_reg;
    logic [BYTE_W-1:0]  byte_reg;
    logic               last_reg;

    // output register
    logic               out_valid_reg, out_valid_next;
    verdict_t           verdict_reg;

    logic               proc_go;
    logic               in_ready;
    scan_in_t           scan_in;
    verdict_t           scan_verdict;

    // ------------------------------------------------------------------
    // Configuration port: always ready, one word-addressed register
    // ------------------------------------------------------------------
    assign pready    = 1'b1;
    assign cfg_hit   = (paddr[2] == REG_MAX_REPEAT);
    assign cfg_write = psel && penable && pwrite && pready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            limit_reg <= LIMIT_RESET;
        else if (cfg_write && cfg_hit)
            limit_reg <= pwdata[LIMIT_W-1:0];
    end

    assign prdata = (psel && !pwrite && cfg_hit) ? APB_DATA_W'(limit_reg) : '0;

    // ------------------------------------------------------------------
    // Handshake: a byte advances into the scanner unless it is a last byte
    // and the previous verdict is still waiting at the output
    // ------------------------------------------------------------------
    assign proc_go  = in_valid_reg && (!last_reg || !out_valid_reg || verdict_ch.ready);
    assign in_ready = !in_valid_reg || proc_go;
    assign pattern_ch.ready = in_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            in_valid_reg <= 1'b0;
        else if (in_ready)
            in_valid_reg <= pattern_ch.valid;
    end

    // hold payload while the item waits in the input register
    always_ff @(posedge clk)
    begin
        if (in_ready && pattern_ch.valid)
        begin
            byte_reg <= pattern_ch.pattern_byte;
            last_reg <= pattern_ch.last;
        end
    end

    assign scan_in.step         = proc_go;
    assign scan_in.last         = last_reg;
    assign scan_in.pattern_byte = byte_reg;

    rpss_scan u_scan (
        .clk                (clk),
        .rst_n              (rst_n),
        .scan_in            (scan_in),
        .max_repeat_product (limit_reg),
        .verdict            (scan_verdict)
    );

    // ------------------------------------------------------------------
    // Output register: load on a last byte, drop once taken
    // ------------------------------------------------------------------
    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (proc_go && last_reg)
            out_valid_next = 1'b1;
        else if (verdict_ch.ready)
            out_valid_next = 1'b0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else
            out_valid_reg <= out_valid_next;
    end

    always_ff @(posedge clk)
    begin
        if (proc_go && last_reg)
            verdict_reg <= scan_verdict;
    end

    assign verdict_ch.valid   = out_valid_reg;
    assign verdict_ch.verdict = verdict_reg;

endmodule

`default_nettype wire

>>> hdl/rpss_checker.sv
// ============================================================================
// rpss_checker
// Port-level checks on the screen's handshakes and verdict codes.
// ============================================================================
`default_nettype none

module rpss_checker (
    input wire logic       clk,
    input wire logic       rst_n,
    input wire logic       in_valid,
    input wire logic       in_ready,
    input wire logic       out_valid,
    input wire logic       out_ready,
    input wire logic [2:0] verdict
);
    import rpss_pkg::*;

    // a verdict left unclaimed stays put
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(verdict))
        else $error("verdict dropped or changed while stalled");

    a_verdict_code: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (verdict == VERDICT_ACCEPT || verdict == VERDICT_NUL ||
                       verdict == VERDICT_TOO_LARGE || verdict == VERDICT_UNBOUNDED ||
                       verdict == VERDICT_BACKREF))
        else $error("verdict code out of range");

    // the input only backs up behind an unclaimed verdict
    a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
        !in_ready |-> out_valid && !out_ready)
        else $error("input stalled without a waiting verdict");

    // with nothing in flight, no verdict can appear from nowhere
    a_no_spurious: assert property (@(posedge clk) disable iff (!rst_n)
        !out_valid && !$past(in_valid) && !in_valid |=> !out_valid)
        else $error("verdict without a pattern byte");

endmodule

bind regex_pattern_safety_screen rpss_checker u_rpss_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (pattern_ch.valid),
    .in_ready  (pattern_ch.ready),
    .out_valid (verdict_ch.valid),
    .out_ready (verdict_ch.ready),
    .verdict   (verdict_ch.verdict)
);

`default_nettype wire
